// ===== rtl/dmpd_pkg.sv =====
// Shared types, constants and helper functions for the delta-modulation pixel decoder.
package dmpd_pkg;

    localparam int unsigned PixW   = 8;
    localparam int unsigned StepW  = 8;
    localparam int unsigned GlenW  = 5;
    localparam int unsigned PosW   = 4;
    localparam int unsigned BitCntW = 3;

    localparam logic [StepW-1:0] StepReset = 8'd16;
    localparam logic [GlenW-1:0] GlenReset = 5'd5;
    localparam logic [GlenW-1:0] MaxGroup  = 5'd16;
    localparam logic [PixW-1:0]  PixMax    = 8'd255;
    localparam logic [BitCntW-1:0] LastBit = 3'd7;

    localparam int unsigned AddrW = 3;
    localparam int unsigned DataW = 32;

    // register index codes (paddr[2])
    typedef enum logic
    {
        REG_STEP_SIZE    = 1'b0,
        REG_GROUP_LENGTH = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic [StepW-1:0] step_size;
        logic [GlenW-1:0] group_length;
    } cfg_t;

    // group length clamped to 1..16
    function automatic logic [GlenW-1:0] eff_len(input logic [GlenW-1:0] glen);
        logic [GlenW-1:0] r;
        begin
            if (glen < 5'd1)
                r = 5'd1;
            else if (glen > MaxGroup)
                r = MaxGroup;
            else
                r = glen;
            return r;
        end
    endfunction

    // one saturating delta step
    function automatic logic [PixW-1:0] delta_step(input logic [PixW-1:0] pred,
                                                   input logic [StepW-1:0] step,
                                                   input logic up);
        logic [PixW:0]   sum;
        logic [PixW-1:0] r;
        begin
            sum = {1'b0, pred} + {1'b0, step};
            if (up)
                r = sum[PixW] ? PixMax : sum[PixW-1:0];
            else
                r = (pred >= step) ? (pred - step) : '0;
            return r;
        end
    endfunction

endpackage

// ===== rtl/dmpd_cfg.sv =====
// APB register block holding step size and group length.
module dmpd_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dmpd_pkg::AddrW-1:0]  paddr,
    input  logic [dmpd_pkg::DataW-1:0]  pwdata,
    output logic [dmpd_pkg::DataW-1:0]  prdata,
    output logic                        pready,
    output dmpd_pkg::cfg_t              cfg
);

    logic [dmpd_pkg::StepW-1:0] step_reg;
    logic [dmpd_pkg::StepW-1:0] step_next;
    logic [dmpd_pkg::GlenW-1:0] glen_reg;
    logic [dmpd_pkg::GlenW-1:0] glen_next;
    logic                       wr_en;
    dmpd_pkg::reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = dmpd_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        step_next = step_reg;
        glen_next = glen_reg;
        if (wr_en)
        begin
            unique case (idx)
                dmpd_pkg::REG_STEP_SIZE:    step_next = pwdata[dmpd_pkg::StepW-1:0];
                dmpd_pkg::REG_GROUP_LENGTH: glen_next = pwdata[dmpd_pkg::GlenW-1:0];
                default:                    step_next = step_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            dmpd_pkg::REG_STEP_SIZE:
                prdata = {{(dmpd_pkg::DataW-dmpd_pkg::StepW){1'b0}}, step_reg};
            dmpd_pkg::REG_GROUP_LENGTH:
                prdata = {{(dmpd_pkg::DataW-dmpd_pkg::GlenW){1'b0}}, glen_reg};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= dmpd_pkg::StepReset;
            glen_reg <= dmpd_pkg::GlenReset;
        end
        else
        begin
            step_reg <= step_next;
            glen_reg <= glen_next;
        end
    end

    assign cfg.step_size    = step_reg;
    assign cfg.group_length = glen_reg;

endmodule

// ===== rtl/dmpd_core.sv =====
// Decode datapath: input byte register, one-bit-per-cycle predictor step unless the output stalls, output register.
module dmpd_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dmpd_pkg::cfg_t              cfg,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [dmpd_pkg::PixW-1:0]   s_byte,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [dmpd_pkg::PixW-1:0]   m_pixel,
    output logic                        m_last
);

    // work register
    logic                          busy_reg;
    logic                          busy_next;
    logic                          abs_reg;
    logic                          abs_next;
    logic [dmpd_pkg::PixW-1:0]     byte_reg;
    logic [dmpd_pkg::PixW-1:0]     byte_next;
    logic [dmpd_pkg::BitCntW-1:0]  cnt_reg;
    logic [dmpd_pkg::BitCntW-1:0]  cnt_next;
    // decoder state
    logic [dmpd_pkg::PixW-1:0]     pred_reg;
    logic [dmpd_pkg::PixW-1:0]     pred_next;
    logic [dmpd_pkg::PosW-1:0]     pos_reg;
    logic [dmpd_pkg::PosW-1:0]     pos_next;
    // output register
    logic                          ovalid_reg;
    logic                          ovalid_next;
    logic [dmpd_pkg::PixW-1:0]     opix_reg;
    logic [dmpd_pkg::PixW-1:0]     opix_next;
    logic                          olast_reg;
    logic                          olast_next;

    logic                          fire;
    logic                          fire_last;
    logic                          accept;
    logic                          item_last;
    logic [dmpd_pkg::PixW-1:0]     step_pix;
    logic [dmpd_pkg::GlenW-1:0]    pos_inc;

    assign item_last = abs_reg || (cnt_reg == dmpd_pkg::LastBit);
    assign fire      = busy_reg && (!ovalid_reg || m_tready);
    assign fire_last = fire && item_last;
    assign s_tready  = !busy_reg || fire_last;
    assign accept    = s_tvalid && s_tready;

    assign step_pix = abs_reg ? byte_reg
                              : dmpd_pkg::delta_step(pred_reg, cfg.step_size, byte_reg[0]);
    assign pos_inc  = {1'b0, pos_reg} + 5'd1;

    always_comb
    begin
        busy_next   = busy_reg;
        abs_next    = abs_reg;
        byte_next   = byte_reg;
        cnt_next    = cnt_reg;
        pred_next   = pred_reg;
        pos_next    = pos_reg;
        ovalid_next = ovalid_reg;
        opix_next   = opix_reg;
        olast_next  = olast_reg;

        if (ovalid_reg && m_tready)
            ovalid_next = 1'b0;

        if (fire)
        begin
            pred_next   = step_pix;
            opix_next   = step_pix;
            olast_next  = item_last;
            ovalid_next = 1'b1;
            byte_next   = {1'b0, byte_reg[dmpd_pkg::PixW-1:1]};
            cnt_next    = cnt_reg + 3'd1;
            if (item_last)
                busy_next = 1'b0;
        end

        if (accept)
        begin
            busy_next = 1'b1;
            abs_next  = (pos_reg == '0);
            byte_next = s_byte;
            cnt_next  = '0;
            if (pos_inc >= dmpd_pkg::eff_len(cfg.group_length))
                pos_next = '0;
            else
                pos_next = pos_inc[dmpd_pkg::PosW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            pred_reg   <= '0;
            pos_reg    <= '0;
            abs_reg    <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
            pred_reg   <= pred_next;
            pos_reg    <= pos_next;
            abs_reg    <= abs_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        opix_reg  <= opix_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_pixel  = opix_reg;
    assign m_last   = olast_reg;

endmodule

// ===== rtl/delta_modulation_pixel_decoder_top.sv =====
// Top level of the delta-modulation pixel decoder.
//
//  channel   dir  signals                                contents
//  s_axis    in   s_tvalid s_tready s_tdata[7:0]         one encoded byte per request
//  m_axis    out  m_tvalid m_tready m_tdata[7:0] m_tlast one pixel per request
//  apb       in   psel penable pwrite paddr pwdata ...   step_size @0x0, group_length @0x4
//
// An absolute byte gives one pixel, a delta byte eight, one pixel per cycle from the
// single predictor step unit while the output register is not stalled.
// The next byte is taken in the cycle its predecessor's last pixel enters the output
// register, so bytes flow without gaps. A stalled m_tready holds the output register
// and the step unit. rst_n clears predictor, group position and valid flags; there is
// no clearing pass.
module delta_modulation_pixel_decoder_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,    // [7:0] in_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,    // [7:0] pixel
    output logic                        m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dmpd_pkg::AddrW-1:0]  paddr,
    input  logic [dmpd_pkg::DataW-1:0]  pwdata,
    output logic [dmpd_pkg::DataW-1:0]  prdata,
    output logic                        pready
);

    dmpd_pkg::cfg_t cfg;

    dmpd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dmpd_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_byte   (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_pixel  (m_tdata),
        .m_last   (m_tlast)
    );

`ifndef SYNTHESIS
    // a stalled pixel that is not the last of its byte means the byte is still in work
    a_no_accept_mid_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && !m_tlast) |-> !s_tready)
        else $error("input request taken while a byte is still being decoded");

    // an accepted byte reaches the output register through the byte register
    a_pixel_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !m_tvalid) |-> ##2 m_tvalid)
        else $error("no pixel after accepted byte");

    // a step_size write lands in the register
    a_step_write: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[2] == dmpd_pkg::REG_STEP_SIZE))
            |=> (cfg.step_size == $past(pwdata[dmpd_pkg::StepW-1:0])))
        else $error("step_size write lost");
`endif

endmodule
